// ===== rtl/least_squares_line_fit_core_assert.svh =====
// Assertion macros for the least-squares line fit core checker.
`ifndef LEAST_SQUARES_LINE_FIT_CORE_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_CORE_ASSERT_SVH

// Same-cycle implication, quiet while in reset.
`define LSLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lslf assertion failed");

// Next-cycle implication, quiet while in reset.
`define LSLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lslf assertion failed");

// Next-cycle implication that also holds across reset.
`define LSLF_ASSERT_NXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lslf assertion failed");

`endif

// ===== rtl/lslf_pkg.sv =====
// Shared constants, codes and command/status types of the line fit core.
package lslf_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned COUNT_W    = $clog2(MAX_POINTS + 1);

  localparam int unsigned SUMX_W  = 27;
  localparam int unsigned SUMY_W  = 27;
  localparam int unsigned SUMXY_W = 42;
  localparam int unsigned SUMXX_W = 41;
  localparam int unsigned SQ_W    = 2 * SAMPLE_W;

  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned SPLIT  = 21;
  localparam int unsigned RES_W  = 32;
  localparam int unsigned MAG_W  = PROD_W;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ICPT_SH   = 8;
  localparam int unsigned DVD_W     = MAG_W + FRAC_BITS;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned PROD_STEPS = 6;
  localparam int unsigned STEP_W     = $clog2(PROD_STEPS);

  localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MUL_SY_SX   = 3'd0,
    MUL_N_XYHI  = 3'd1,
    MUL_N_XYLO  = 3'd2,
    MUL_SX_SX   = 3'd3,
    MUL_N_XXHI  = 3'd4,
    MUL_N_XXLO  = 3'd5,
    MUL_G_SX    = 3'd6
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE       = 3'd0,
    ACC_NUM_LOAD   = 3'd1,
    ACC_NUM_SUB_HI = 3'd2,
    ACC_NUM_SUB    = 3'd3,
    ACC_DEN_LOAD   = 3'd4,
    ACC_DEN_SUB_HI = 3'd5,
    ACC_DEN_SUB    = 3'd6
  } acc_op_t;

  typedef struct packed {
    logic     acc_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     num_load_sy;
    logic     div_start;
    logic     div_icpt;
    logic     store_grad;
    logic     store_icpt;
    logic     decide;
    logic     load_out;
    logic     clear;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/lslf_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating signed result.
module lslf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        shift_frac,
  input  logic                        neg,
  input  logic [lslf_pkg::MAG_W-1:0]  dvd_mag,
  input  logic [lslf_pkg::MAG_W-1:0]  dsr_mag,
  output logic                        done,
  output logic [lslf_pkg::RES_W-1:0]  quot
);
  import lslf_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [MAG_W-1:0]     dsr_r;
  logic [MAG_W-1:0]     rem_r;
  logic [RES_W-1:0]     quo_r;
  logic                 ovf_r;
  logic                 neg_r;

  logic [MAG_W:0]       rem_sh;
  logic [MAG_W:0]       rem_diff;
  logic                 ge;
  logic [MAG_W-1:0]     rem_nxt;
  logic [RES_W-1:0]     lim;
  logic [RES_W-1:0]     mag;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign ge       = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt  = ge ? rem_diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      dvd_r <= shift_frac ? {dvd_mag, {FRAC_BITS{1'b0}}} : {{FRAC_BITS{1'b0}}, dvd_mag};
      dsr_r <= dsr_mag;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      neg_r <= neg;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      // quotient bits above the result width only mean saturation
      ovf_r <= ovf_r | quo_r[RES_W-1];
      quo_r <= {quo_r[RES_W-2:0], ge};
    end
  end

  assign lim  = neg_r ? SAT_NEG : SAT_POS;
  assign mag  = (ovf_r || quo_r > lim) ? lim : quo_r;
  assign quot = neg_r ? (RES_W'(0) - mag) : mag;
  assign done = done_r;

endmodule

// ===== rtl/lslf_dp.sv =====
// Datapath: running sums, shared multiplier, num/den accumulators, divider, results.
module lslf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lslf_pkg::cmd_t                      cmd,
  output lslf_pkg::sts_t                      sts,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0] in_x,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0] in_y,
  output logic signed [lslf_pkg::RES_W-1:0]   out_gradient,
  output logic signed [lslf_pkg::RES_W-1:0]   out_intercept,
  output logic                                out_degenerate,
  output logic                                out_overflowed
);
  import lslf_pkg::*;

  logic [SUMX_W-1:0]  sum_x_r;
  logic [SUMY_W-1:0]  sum_y_r;
  logic [SUMXY_W-1:0] sum_xy_r;
  logic [SUMXX_W-1:0] sum_xx_r;
  logic [COUNT_W-1:0] count_r;
  logic               dropped_r;

  logic signed [SQ_W-1:0] xy_prod;
  logic signed [SQ_W-1:0] xx_prod;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  acc_op_t                  pend_r;
  logic [PROD_W-1:0]        num_r;
  logic [PROD_W-1:0]        den_r;
  logic [PROD_W-1:0]        prod_hi;

  logic [RES_W-1:0] grad_r;
  logic [RES_W-1:0] icpt_r;
  logic             degen_r;

  logic [RES_W-1:0] out_grad_r;
  logic [RES_W-1:0] out_icpt_r;
  logic             out_degen_r;
  logic             out_ovf_r;

  logic [MAG_W-1:0] num_mag;
  logic [MAG_W-1:0] den_mag;
  logic [MAG_W-1:0] dsr_mag;
  logic             div_neg;
  logic             div_done;
  logic [RES_W-1:0] div_q;

  assign xy_prod = in_x * in_y;
  assign xx_prod = in_x * in_x;

  // point accumulation; count saturates at capacity and later points are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_xy_r  <= '0;
      sum_xx_r  <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.clear) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_xy_r  <= '0;
      sum_xx_r  <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count_r != COUNT_W'(MAX_POINTS)) begin
        sum_x_r  <= sum_x_r + {{(SUMX_W-SAMPLE_W){in_x[SAMPLE_W-1]}}, in_x};
        sum_y_r  <= sum_y_r + {{(SUMY_W-SAMPLE_W){in_y[SAMPLE_W-1]}}, in_y};
        sum_xy_r <= sum_xy_r + {{(SUMXY_W-SQ_W){xy_prod[SQ_W-1]}}, xy_prod};
        sum_xx_r <= sum_xx_r + {{(SUMXX_W-SQ_W){xx_prod[SQ_W-1]}}, xx_prod};
        count_r  <= count_r + 1'b1;
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // shared multiplier operand select; wide sums go in as a signed high half
  // and an unsigned low half
  always_comb begin
    mul_a = {{(MUL_W-COUNT_W){1'b0}}, count_r};
    mul_b = {{(MUL_W-SUMX_W){sum_x_r[SUMX_W-1]}}, sum_x_r};
    case (cmd.mul_sel)
      MUL_SY_SX: begin
        mul_a = {{(MUL_W-SUMY_W){sum_y_r[SUMY_W-1]}}, sum_y_r};
      end
      MUL_N_XYHI: begin
        mul_b = {{(MUL_W-(SUMXY_W-SPLIT)){sum_xy_r[SUMXY_W-1]}}, sum_xy_r[SUMXY_W-1:SPLIT]};
      end
      MUL_N_XYLO: begin
        mul_b = {{(MUL_W-SPLIT){1'b0}}, sum_xy_r[SPLIT-1:0]};
      end
      MUL_SX_SX: begin
        mul_a = {{(MUL_W-SUMX_W){sum_x_r[SUMX_W-1]}}, sum_x_r};
      end
      MUL_N_XXHI: begin
        mul_b = {{(MUL_W-(SUMXX_W-SPLIT)){sum_xx_r[SUMXX_W-1]}}, sum_xx_r[SUMXX_W-1:SPLIT]};
      end
      MUL_N_XXLO: begin
        mul_b = {{(MUL_W-SPLIT){1'b0}}, sum_xx_r[SPLIT-1:0]};
      end
      MUL_G_SX: begin
        mul_a = grad_r;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod_hi = prod_r <<< SPLIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= ACC_NONE;
    end else begin
      pend_r <= cmd.acc_op;
    end
  end

  // product registered, accumulated in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.num_load_sy) begin
      num_r <= {{(PROD_W-SUMY_W-FRAC_BITS){sum_y_r[SUMY_W-1]}}, sum_y_r, {FRAC_BITS{1'b0}}};
    end else begin
      case (pend_r)
        ACC_NUM_LOAD:   num_r <= prod_r;
        ACC_NUM_SUB_HI: num_r <= num_r - prod_hi;
        ACC_NUM_SUB:    num_r <= num_r - prod_r;
        default:        num_r <= num_r;
      endcase
    end
    case (pend_r)
      ACC_DEN_LOAD:   den_r <= prod_r;
      ACC_DEN_SUB_HI: den_r <= den_r - prod_hi;
      ACC_DEN_SUB:    den_r <= den_r - prod_r;
      default:        den_r <= den_r;
    endcase
  end

  assign num_mag = num_r[PROD_W-1] ? (PROD_W'(0) - num_r) : num_r;
  assign den_mag = den_r[PROD_W-1] ? (PROD_W'(0) - den_r) : den_r;
  assign dsr_mag = cmd.div_icpt ? {{(MAG_W-COUNT_W-ICPT_SH){1'b0}}, count_r, {ICPT_SH{1'b0}}}
                                : den_mag;
  assign div_neg = cmd.div_icpt ? num_r[PROD_W-1] : (num_r[PROD_W-1] ^ den_r[PROD_W-1]);

  lslf_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .shift_frac (!cmd.div_icpt),
    .neg        (div_neg),
    .dvd_mag    (num_mag),
    .dsr_mag    (dsr_mag),
    .done       (div_done),
    .quot       (div_q)
  );

  assign sts.degen    = (den_r == '0) || (count_r == '0);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      degen_r <= sts.degen;
      if (sts.degen) begin
        grad_r <= '0;
        icpt_r <= '0;
      end
    end
    if (cmd.store_grad) begin
      grad_r <= div_q;
    end
    if (cmd.store_icpt) begin
      icpt_r <= div_q;
    end
    if (cmd.load_out) begin
      out_grad_r  <= grad_r;
      out_icpt_r  <= icpt_r;
      out_degen_r <= degen_r;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_gradient   = out_grad_r;
  assign out_intercept  = out_icpt_r;
  assign out_degenerate = out_degen_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== rtl/lslf_ctrl.sv =====
// Controller: sequences accumulation, products, both divisions and result hand-off.
module lslf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lslf_pkg::cmd_t cmd,
  input  lslf_pkg::sts_t sts
);
  import lslf_pkg::*;

  typedef enum logic [9:0] {
    S_ACCUM    = 10'b00_0000_0001,
    S_PROD     = 10'b00_0000_0010,
    S_CHECK    = 10'b00_0000_0100,
    S_DECIDE   = 10'b00_0000_1000,
    S_DIV_G    = 10'b00_0001_0000,
    S_ICPT_MUL = 10'b00_0010_0000,
    S_ICPT_SUB = 10'b00_0100_0000,
    S_DIV_I_ST = 10'b00_1000_0000,
    S_DIV_I    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_ACCUM);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_ACCUM: begin
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            state_nxt = S_PROD;
            step_nxt  = '0;
          end
        end
      end
      S_PROD: begin
        // N = Sy*Sx - n*Sxy, D = Sx*Sx - n*Sxx
        case (step_r)
          3'd0: begin
            cmd.mul_sel = MUL_SY_SX;
            cmd.acc_op  = ACC_NUM_LOAD;
          end
          3'd1: begin
            cmd.mul_sel = MUL_N_XYHI;
            cmd.acc_op  = ACC_NUM_SUB_HI;
          end
          3'd2: begin
            cmd.mul_sel = MUL_N_XYLO;
            cmd.acc_op  = ACC_NUM_SUB;
          end
          3'd3: begin
            cmd.mul_sel = MUL_SX_SX;
            cmd.acc_op  = ACC_DEN_LOAD;
          end
          3'd4: begin
            cmd.mul_sel = MUL_N_XXHI;
            cmd.acc_op  = ACC_DEN_SUB_HI;
          end
          3'd5: begin
            cmd.mul_sel = MUL_N_XXLO;
            cmd.acc_op  = ACC_DEN_SUB;
          end
          default: begin
            cmd.acc_op = ACC_NONE;
          end
        endcase
        if (step_r == STEP_W'(PROD_STEPS - 1)) begin
          state_nxt = S_CHECK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_CHECK: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.degen) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_G;
        end
      end
      S_DIV_G: begin
        if (sts.div_done) begin
          cmd.store_grad = 1'b1;
          state_nxt      = S_ICPT_MUL;
        end
      end
      S_ICPT_MUL: begin
        cmd.num_load_sy = 1'b1;
        cmd.mul_sel     = MUL_G_SX;
        cmd.acc_op      = ACC_NUM_SUB;
        state_nxt       = S_ICPT_SUB;
      end
      S_ICPT_SUB: begin
        state_nxt = S_DIV_I_ST;
      end
      S_DIV_I_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_icpt  = 1'b1;
        state_nxt     = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.div_icpt = 1'b1;
        if (sts.div_done) begin
          cmd.store_icpt = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACCUM;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

endmodule

// ===== rtl/least_squares_line_fit_core.sv =====
// Intake: one point per cycle while accumulating; a fit result is valid once the request
//   marked last has run through products, decide and both divisions (none when degenerate).
// Throughput: points stream at 1/cycle; the fit then holds the input off, set by the
//   bit-serial divider (two divisions) and the 6-pass multiplier, until the result moves on.
// Reset (rst_n low, synchronous): sums, count, drop flag cleared, controller to accumulate,
//   no result pending.
module least_squares_line_fit_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0] in_x,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0] in_y,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lslf_pkg::RES_W-1:0]    out_gradient,
  output logic signed [lslf_pkg::RES_W-1:0]    out_intercept,
  output logic                                 out_degenerate,
  output logic                                 out_overflowed
);
  import lslf_pkg::*;

  // Flow of one set:
  //   accumulate - each request adds x, y, x*y, x*x and bumps the count, until
  //                capacity; beyond it the point is dropped and flagged.
  //   products   - one 32x32 multiplier, six passes, builds N = Sy*Sx - n*Sxy and
  //                D = Sx^2 - n*Sxx in 64-bit accumulators (wide sums split in halves).
  //   decide     - D == 0 or n == 0 gives the degenerate result with zero outputs.
  //   gradient   - |N| << 16 / |D| on the restoring divider, truncated, saturated.
  //   intercept  - (Sy << 16) - g*Sx, then divided by n*256 the same way.
  //   done       - result goes to the output register once it is free, the sums clear
  //                and new points are taken while the result waits downstream.

  cmd_t cmd;
  sts_t sts;

  lslf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lslf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_x           (in_x),
    .in_y           (in_y),
    .out_gradient   (out_gradient),
    .out_intercept  (out_intercept),
    .out_degenerate (out_degenerate),
    .out_overflowed (out_overflowed)
  );

endmodule

// ===== rtl/lslf_chk.sv =====
// Port-level checker for the line fit core, bound to the top level.
`include "least_squares_line_fit_core_assert.svh"

module lslf_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic signed [lslf_pkg::SAMPLE_W-1:0] in_x,
  input logic signed [lslf_pkg::SAMPLE_W-1:0] in_y,
  input logic                                 in_last,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [lslf_pkg::RES_W-1:0]    out_gradient,
  input logic signed [lslf_pkg::RES_W-1:0]    out_intercept,
  input logic                                 out_degenerate,
  input logic                                 out_overflowed
);

  // reset leaves no result pending
  `LSLF_ASSERT_NXT_ANY(a_rst_no_result, !rst_n, !out_valid)

  // the last point of a set stops intake while the fit runs
  `LSLF_ASSERT_NXT(a_last_stalls, in_valid && in_ready && in_last, !in_ready)

  // a degenerate fit carries zero slope and intercept
  `LSLF_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate,
                   out_gradient == '0 && out_intercept == '0)

  // a new result only appears once intake has been closed
  `LSLF_ASSERT_IMP(a_result_after_fit, $rose(out_valid), $past(!in_ready))

  // a waiting result holds
  `LSLF_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_gradient) && $stable(out_intercept))

endmodule

bind least_squares_line_fit_core lslf_chk u_lslf_chk (.*);

// ===== test/least_squares_line_fit_core_tb.sv =====
// Self-checking testbench for the least-squares line fit core: directed table, then random sets.
`timescale 1ns / 1ps

module least_squares_line_fit_core_tb;
  import lslf_pkg::*;

  // Slowest fit, in cycles after the closing point; sets the final drain wait.
  localparam int unsigned FIT_LATENCY = 174;
  localparam int unsigned RAND_POINTS = 1450;
  localparam int unsigned IDLE_PCT    = 37;
  // Receiver hold-off and calm windows, in cycles since the receiver started.
  localparam int unsigned HOLD_START  = 2400;
  localparam int unsigned HOLD_LEN    = 900;
  localparam int unsigned CALM_START  = 6000;
  localparam int unsigned CALM_LEN    = 3000;
  localparam int unsigned LONG_SET    = MAX_POINTS + 1;

  // One fit result as it appears on the out_ ports.
  typedef struct packed {
    logic signed [RES_W-1:0] gradient;
    logic signed [RES_W-1:0] intercept;
    logic                    degenerate;
    logic                    overflowed;
  } fit_res_t;

  // One row of the directed table. When hand_checked is set, res holds the
  // result worked out by hand and replaces the predicted one.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       last;
    logic                       hand_checked;
    fit_res_t                   res;
  } pt_row_t;

  localparam fit_res_t NO_FIT = '0;
  localparam fit_res_t DEGEN  = '{32'sd0, 32'sd0, 1'b1, 1'b0};

  localparam int unsigned N_ROWS = 24;

  // Directed table: degenerate sets, exact unit slopes, a flat line, both
  // saturated slopes, full-scale corners, a plain three-point line and scattered points.
  localparam pt_row_t DIR_ROWS [0:N_ROWS-1] = '{
    // single point
    '{16'sd0, 16'sd0, 1'b1, 1'b1, DEGEN},
    '{-16'sd32768, 16'sd32767, 1'b1, 1'b1, DEGEN},
    // two points, same x at full scale
    '{16'sd32767, -16'sd32768, 1'b0, 1'b0, NO_FIT},
    '{16'sd32767, 16'sd32767, 1'b1, 1'b1, DEGEN},
    // y = x
    '{16'sd0, 16'sd0, 1'b0, 1'b0, NO_FIT},
    '{16'sd256, 16'sd256, 1'b1, 1'b1, '{32'sd65536, 32'sd0, 1'b0, 1'b0}},
    // y = -x
    '{16'sd0, 16'sd0, 1'b0, 1'b0, NO_FIT},
    '{16'sd256, -16'sd256, 1'b1, 1'b1, '{-32'sd65536, 32'sd0, 1'b0, 1'b0}},
    // y = 2.0, flat
    '{-16'sd256, 16'sd512, 1'b0, 1'b0, NO_FIT},
    '{16'sd256, 16'sd512, 1'b1, 1'b1, '{32'sd0, 32'sd131072, 1'b0, 1'b0}},
    // slope far above range, saturates positive
    '{16'sd0, -16'sd32768, 1'b0, 1'b0, NO_FIT},
    '{16'sd1, 16'sd32767, 1'b1, 1'b0, NO_FIT},
    // slope far below range, saturates negative
    '{16'sd0, 16'sd32767, 1'b0, 1'b0, NO_FIT},
    '{16'sd1, -16'sd32768, 1'b1, 1'b0, NO_FIT},
    // four full-scale corners
    '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, NO_FIT},
    '{16'sd32767, 16'sd32767, 1'b0, 1'b0, NO_FIT},
    '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, NO_FIT},
    '{16'sd32767, -16'sd32768, 1'b1, 1'b0, NO_FIT},
    // y = 2x + 1
    '{16'sd0, 16'sd256, 1'b0, 1'b0, NO_FIT},
    '{16'sd256, 16'sd768, 1'b0, 1'b0, NO_FIT},
    '{16'sd512, 16'sd1280, 1'b1, 1'b1, '{32'sd131072, 32'sd65536, 1'b0, 1'b0}},
    // scattered fractional points
    '{16'sd100, -16'sd37, 1'b0, 1'b0, NO_FIT},
    '{-16'sd5000, 16'sd1234, 1'b0, 1'b0, NO_FIT},
    '{16'sd31000, -16'sd20000, 1'b1, 1'b0, NO_FIT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_x = '0;
  logic signed [SAMPLE_W-1:0] in_y = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [RES_W-1:0]    out_gradient;
  logic signed [RES_W-1:0]    out_intercept;
  logic                       out_degenerate;
  logic                       out_overflowed;

  // Side channel that travels with the request: hand-worked result, if any.
  logic     req_hand_checked = 1'b0;
  fit_res_t req_hand_res = '0;

  // Predictor state, one copy of the core's running sums.
  logic signed [SUMX_W-1:0]  acc_x  = '0;
  logic signed [SUMY_W-1:0]  acc_y  = '0;
  logic signed [SUMXY_W-1:0] acc_xy = '0;
  logic signed [SUMXX_W-1:0] acc_xx = '0;
  logic [COUNT_W-1:0]        acc_n  = '0;
  logic                      acc_dropped = 1'b0;

  fit_res_t    pending_fits [$];
  int unsigned mismatches = 0;
  logic        send_calm = 1'b0;

  least_squares_line_fit_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_gradient  (out_gradient),
    .out_intercept (out_intercept),
    .out_degenerate(out_degenerate),
    .out_overflowed(out_overflowed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop in case the core hangs.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Signed (a << frac) / b on 64-bit patterns, truncated toward zero and
  // clipped to the 32-bit signed range.
  function automatic logic [RES_W-1:0] sat_quot(input logic [63:0] a, input logic [63:0] b,
                                                input int unsigned frac);
    logic        neg;
    logic        carry;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] lim;
    int unsigned k;
    neg = a[63] ^ b[63];
    ua  = a[63] ? (64'd0 - a) : a;
    ub  = b[63] ? (64'd0 - b) : b;
    if (ub == 64'd0) return '0;
    q   = ua / ub;
    r   = ua % ub;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    // integer part alone already out of range
    if (q > (lim >> frac)) return neg ? SAT_NEG : SAT_POS;
    // long division on the remainder for the fraction bits
    for (k = 0; k < frac; k++) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= ub) begin
        r = r - ub;
        q[0] = 1'b1;
      end
    end
    if (q > lim) q = lim;
    q = neg ? (64'd0 - q) : q;
    return q[RES_W-1:0];
  endfunction

  // Folds one accepted point into the sums; on a closing point returns 1
  // with the fit it should produce and clears the sums.
  function automatic logic fit_point(input logic signed [SAMPLE_W-1:0] x,
                                     input logic signed [SAMPLE_W-1:0] y,
                                     input logic last, output fit_res_t res);
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [63:0]        n;
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [63:0] sxy;
    logic signed [63:0] sxx;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        g64;
    logic [63:0]        t;
    xs  = 64'(x);
    ys  = 64'(y);
    res = NO_FIT;
    if (acc_n < MAX_POINTS) begin
      acc_x  = SUMX_W'(acc_x + xs);
      acc_y  = SUMY_W'(acc_y + ys);
      acc_xy = SUMXY_W'(acc_xy + xs * ys);
      acc_xx = SUMXX_W'(acc_xx + xs * xs);
      acc_n  = acc_n + 1'b1;
    end else begin
      acc_dropped = 1'b1;
    end
    if (!last) return 1'b0;

    n   = 64'(acc_n);
    sx  = 64'(acc_x);
    sy  = 64'(acc_y);
    sxy = 64'(acc_xy);
    sxx = 64'(acc_xx);
    num = sy * sx - n * sxy;
    den = sx * sx - n * sxx;
    res.degenerate = (den == 64'd0) || (n == 64'd0);
    res.overflowed = acc_dropped;
    if (!res.degenerate) begin
      res.gradient  = sat_quot(num, den, FRAC_BITS);
      // intercept uses the clipped slope, numerator in 2^-24 units
      g64           = {{(64-RES_W){res.gradient[RES_W-1]}}, res.gradient};
      t             = (sy <<< FRAC_BITS) - g64 * sx;
      res.intercept = sat_quot(t, n << ICPT_SH, 0);
    end

    acc_x       = '0;
    acc_y       = '0;
    acc_xy      = '0;
    acc_xx      = '0;
    acc_n       = '0;
    acc_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [RES_W-1:0] got,
                               input logic [RES_W-1:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, $signed(got),
             $signed(want), $time);
    mismatches++;
  endtask

  // Scoreboard: results are compared before new requests are folded in.
  always @(posedge clk) begin : score
    fit_res_t got;
    fit_res_t want;
    fit_res_t pred;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_gradient, out_intercept, out_degenerate, out_overflowed};
        if (pending_fits.size() == 0) begin
          note_mismatch("result with no fit pending", got.gradient, '0);
        end else begin
          want = pending_fits.pop_front();
          if (got.gradient !== want.gradient)
            note_mismatch("gradient", got.gradient, want.gradient);
          if (got.intercept !== want.intercept)
            note_mismatch("intercept", got.intercept, want.intercept);
          if (got.degenerate !== want.degenerate)
            note_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
          if (got.overflowed !== want.overflowed)
            note_mismatch("overflowed", 32'(got.overflowed), 32'(want.overflowed));
        end
      end
      if (in_valid && in_ready) begin
        if (fit_point(in_x, in_y, in_last, pred))
          pending_fits.push_back(req_hand_checked ? req_hand_res : pred);
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the core backs up into
  // its input, and a calm window with out_ready held high.
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else if (cyc >= CALM_START && cyc < CALM_START + CALM_LEN) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_point(input logic signed [SAMPLE_W-1:0] x,
                            input logic signed [SAMPLE_W-1:0] y, input logic last,
                            input logic hand_checked, input fit_res_t hand_res);
    while (!send_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_x             <= x;
    in_y             <= y;
    in_last          <= last;
    req_hand_checked <= hand_checked;
    req_hand_res     <= hand_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender: directed table, then random sets, then drain and verdict.
  initial begin
    int unsigned row;
    int unsigned sent;
    int unsigned len;
    int unsigned p;
    int unsigned kind;
    int          slope;
    int          offset;
    int          span;
    int          xv;
    int          yv;
    logic        long_done;

    while (!rst_n) @(posedge clk);

    for (row = 0; row < N_ROWS; row++)
      send_point(DIR_ROWS[row].x, DIR_ROWS[row].y, DIR_ROWS[row].last,
                 DIR_ROWS[row].hand_checked, DIR_ROWS[row].res);

    sent      = 0;
    long_done = 1'b0;
    while (sent < RAND_POINTS) begin
      send_calm = (sent >= 100 && sent < 350);
      kind = $urandom_range(0, 99);
      if (!long_done && sent >= 400) begin
        // one set past capacity: the closing point itself is dropped
        long_done = 1'b1;
        for (p = 0; p < LONG_SET; p++) begin
          xv = $urandom_range(0, 65535) - 32768;
          yv = xv / 2 + int'($urandom_range(0, 64)) - 32;
          send_point(16'(xv), clip16(yv), p == LONG_SET - 1, 1'b0, NO_FIT);
        end
        sent += LONG_SET;
      end else if (kind < 60) begin
        // noisy straight line, the common case
        len    = $urandom_range(2, 12);
        slope  = $urandom_range(0, 2048) - 1024;
        offset = $urandom_range(0, 8000) - 4000;
        span   = ($urandom_range(0, 3) == 0) ? 32767 : 4000;
        for (p = 0; p < len; p++) begin
          xv = $urandom_range(0, 2 * span) - span;
          yv = (slope * xv) / 256 + offset + int'($urandom_range(0, 16)) - 8;
          send_point(16'(xv), clip16(yv), p == len - 1, 1'b0, NO_FIT);
        end
        sent += len;
      end else if (kind < 75) begin
        // unrelated full-range points
        len = $urandom_range(1, 8);
        for (p = 0; p < len; p++)
          send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     p == len - 1, 1'b0, NO_FIT);
        sent += len;
      end else if (kind < 85) begin
        // all x equal: no slope
        len = $urandom_range(1, 6);
        xv  = $urandom_range(0, 65535);
        for (p = 0; p < len; p++)
          send_point(16'(xv), 16'($urandom_range(0, 65535)), p == len - 1, 1'b0, NO_FIT);
        sent += len;
      end else begin
        // short sets of edge values
        len = $urandom_range(1, 3);
        for (p = 0; p < len; p++) begin
          case ($urandom_range(0, 5))
            0: xv = -32768;
            1: xv = 32767;
            2: xv = 0;
            3: xv = -1;
            4: xv = 1;
            default: xv = $urandom_range(0, 65535);
          endcase
          yv = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
          send_point(16'(xv), 16'(yv), p == len - 1, 1'b0, NO_FIT);
        end
        sent += len;
      end
    end
    send_calm = 1'b0;

    in_valid <= 1'b0;
    in_last  <= 1'b0;
    @(posedge clk);
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (2 * FIT_LATENCY) @(posedge clk);

    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lslf_pkg.sv
rtl/lslf_div.sv
rtl/lslf_dp.sv
rtl/lslf_ctrl.sv
rtl/least_squares_line_fit_core.sv
rtl/lslf_chk.sv
test/least_squares_line_fit_core_tb.sv
